@@ rtl/tthd_pkg.sv @@
// Package for the touch tap and hold detector.
// Holds the request opcodes, register indexes, field widths and reset values.
// Depends on nothing; used by touch_tap_hold_detector.
`default_nettype none

package tthd_pkg;

   localparam int unsigned READING_W = 8;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned MS_W      = 16;
   localparam int unsigned TAPS_W    = 8;
   localparam int unsigned OPCODE_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned REQ_W     = 64;
   localparam int unsigned RSP_W     = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_UPDATE    = 3'd0,
      OP_READ_TAPS = 3'd1,
      OP_MATCH     = 3'd2,
      OP_HOLD      = 3'd3,
      OP_HOLD_ONCE = 3'd4,
      OP_RELEASE   = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_THRESHOLD     = 3'd0,
      REG_DEBOUNCE      = 3'd1,
      REG_HOLD          = 3'd2,
      REG_TAP_GAP       = 3'd3,
      REG_RELEASE_RESET = 3'd4
   } reg_idx_type;

   localparam logic [READING_W-1:0] THRESHOLD_RST     = 8'd40;
   localparam logic [MS_W-1:0]      DEBOUNCE_RST      = 16'd50;
   localparam logic [MS_W-1:0]      HOLD_RST          = 16'd500;
   localparam logic [MS_W-1:0]      TAP_GAP_RST       = 16'd300;
   localparam logic [MS_W-1:0]      RELEASE_RESET_RST = 16'd500;

endpackage

`default_nettype wire

@@ rtl/touch_tap_hold_detector.sv @@
// Touch key qualifier: debounce, tap counting, hold detection and queries.
// Depends on tthd_pkg for opcodes, register indexes, widths and reset values.
//
// One request is accepted in every cycle while the output can drain, and each
// yields exactly one response: the request is captured in an input register,
// the key state is updated by one pass of compare and wrapping-subtract logic,
// and the response sits in an output register. The output register may hold a
// response while the next request waits in the input register, so a stalled
// response channel only stops intake once both registers are full.
`default_nettype none

module touch_tap_hold_detector (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata, lowest bit up: first_reading[7:0], second_reading[7:0],
   // third_reading[7:0], time_ms[31:0], wanted_taps[7:0].
   input  wire logic [63:0] req_tdata,
   // req_tuser: opcode[2:0].
   input  wire logic [2:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata, lowest bit up: answer[0], tap_total[7:0], zero padding[6:0].
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned RW = tthd_pkg::READING_W;
   localparam int unsigned TW = tthd_pkg::TIME_W;
   localparam int unsigned MW = tthd_pkg::MS_W;
   localparam int unsigned NW = tthd_pkg::TAPS_W;

   logic [RW-1:0] threshold_ff;
   logic [MW-1:0] debounce_ff, hold_ms_ff, tap_gap_ff, release_reset_ff;

   logic                       in_valid_ff;
   logic [2:0]                 in_op_ff;
   logic [RW-1:0]              in_r1_ff, in_r2_ff, in_r3_ff;
   logic [TW-1:0]              in_time_ff;
   logic [NW-1:0]              in_want_ff;

   logic                       out_valid_ff;
   logic                       out_answer_ff, out_answer_in;
   logic [NW-1:0]              out_taps_ff, out_taps_in;

   logic                       released_ff, released_in;
   logic [TW-1:0]              press_start_ff, press_start_in;
   logic [TW-1:0]              press_end_ff, press_end_in;
   logic [TW-1:0]              last_touch_ff, last_touch_in;
   logic [NW-1:0]              running_ff, running_in;
   logic [NW-1:0]              latched_ff, latched_in;
   logic                       hold_active_ff, hold_active_in;
   logic                       hold_rep_ff, hold_rep_in;
   logic                       cleared_ff, cleared_in;
   logic                       hold_seen_ff, hold_seen_in;

   logic          advance;
   logic          touched;
   logic [RW-1:0] hi_reading;
   logic          rel1, rel2, c_press, c_release, c_hold, c_clear;
   logic [TW-1:0] start1, end2;
   logic [TW-1:0] deb_ext, hold_ext, gap_ext, rr_ext;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_taps_ff, out_answer_ff};

   assign deb_ext  = {{(TW-MW){1'b0}}, debounce_ff};
   assign hold_ext = {{(TW-MW){1'b0}}, hold_ms_ff};
   assign gap_ext  = {{(TW-MW){1'b0}}, tap_gap_ff};
   assign rr_ext   = {{(TW-MW){1'b0}}, release_reset_ff};

   assign hi_reading = (in_r1_ff > in_r2_ff) ? in_r1_ff : in_r2_ff;
   assign touched    = (hi_reading <= threshold_ff) || (in_r3_ff <= threshold_ff);

   // The update steps are applied in order, each seeing the previous step's result.
   always_comb begin
      c_press   = released_ff && touched && ((in_time_ff - press_end_ff) >= deb_ext);
      rel1      = c_press ? 1'b0 : released_ff;
      start1    = c_press ? in_time_ff : press_start_ff;
      c_release = !rel1 && !touched && ((in_time_ff - last_touch_ff) >= deb_ext);
      rel2      = c_release ? 1'b1 : rel1;
      end2      = c_release ? in_time_ff : press_end_ff;
      c_hold    = !rel2 && ((in_time_ff - start1) >= hold_ext);
      c_clear   = rel2 && ((in_time_ff + gap_ext - end2) >= rr_ext);
   end

   always_comb begin
      released_in    = released_ff;
      press_start_in = press_start_ff;
      press_end_in   = press_end_ff;
      last_touch_in  = last_touch_ff;
      running_in     = running_ff;
      latched_in     = latched_ff;
      hold_active_in = hold_active_ff;
      hold_rep_in    = hold_rep_ff;
      cleared_in     = cleared_ff;
      hold_seen_in   = hold_seen_ff;
      out_answer_in  = 1'b0;
      out_taps_in    = '0;
      case (tthd_pkg::op_type'(in_op_ff))
         tthd_pkg::OP_UPDATE: begin
            released_in    = rel2;
            press_start_in = start1;
            press_end_in   = end2;
            if (c_release && ((in_time_ff - start1) < hold_ext)) begin
               running_in = running_ff + 1'b1;
               cleared_in = 1'b0;
            end
            if (c_hold) begin
               hold_active_in = 1'b1;
               cleared_in     = 1'b0;
            end
            if (!cleared_in && rel2 && ((in_time_ff - end2) >= gap_ext)) begin
               latched_in = running_in;
               running_in = '0;
               cleared_in = 1'b1;
            end
            if (c_clear) begin
               hold_active_in = 1'b0;
               hold_rep_in    = 1'b0;
               latched_in     = '0;
            end
            if (touched) begin
               last_touch_in = in_time_ff;
            end
            out_answer_in = touched;
         end
         tthd_pkg::OP_READ_TAPS: begin
            out_taps_in = latched_ff;
            latched_in  = '0;
         end
         tthd_pkg::OP_MATCH: begin
            if (latched_ff == in_want_ff) begin
               latched_in    = '0;
               out_answer_in = 1'b1;
            end
         end
         tthd_pkg::OP_HOLD: begin
            out_answer_in = hold_active_ff;
         end
         tthd_pkg::OP_HOLD_ONCE: begin
            if (hold_active_ff && !hold_rep_ff) begin
               hold_rep_in   = 1'b1;
               out_answer_in = 1'b1;
            end
         end
         tthd_pkg::OP_RELEASE: begin
            if (hold_active_ff) begin
               hold_seen_in = 1'b1;
            end else if (hold_seen_ff) begin
               hold_seen_in  = 1'b0;
               out_answer_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= tthd_pkg::THRESHOLD_RST;
         debounce_ff      <= tthd_pkg::DEBOUNCE_RST;
         hold_ms_ff       <= tthd_pkg::HOLD_RST;
         tap_gap_ff       <= tthd_pkg::TAP_GAP_RST;
         release_reset_ff <= tthd_pkg::RELEASE_RESET_RST;
      end else if (csr_valid) begin
         case (tthd_pkg::reg_idx_type'(csr_index))
            tthd_pkg::REG_THRESHOLD:     threshold_ff     <= csr_data[RW-1:0];
            tthd_pkg::REG_DEBOUNCE:      debounce_ff      <= csr_data;
            tthd_pkg::REG_HOLD:          hold_ms_ff       <= csr_data;
            tthd_pkg::REG_TAP_GAP:       tap_gap_ff       <= csr_data;
            tthd_pkg::REG_RELEASE_RESET: release_reset_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         released_ff    <= 1'b1;
         press_start_ff <= '0;
         press_end_ff   <= '0;
         last_touch_ff  <= '0;
         running_ff     <= '0;
         latched_ff     <= '0;
         hold_active_ff <= 1'b0;
         hold_rep_ff    <= 1'b0;
         cleared_ff     <= 1'b1;
         hold_seen_ff   <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            released_ff    <= released_in;
            press_start_ff <= press_start_in;
            press_end_ff   <= press_end_in;
            last_touch_ff  <= last_touch_in;
            running_ff     <= running_in;
            latched_ff     <= latched_in;
            hold_active_ff <= hold_active_in;
            hold_rep_ff    <= hold_rep_in;
            cleared_ff     <= cleared_in;
            hold_seen_ff   <= hold_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_r1_ff   <= req_tdata[7:0];
         in_r2_ff   <= req_tdata[15:8];
         in_r3_ff   <= req_tdata[23:16];
         in_time_ff <= req_tdata[55:24];
         in_want_ff <= req_tdata[63:56];
      end
      if (advance) begin
         out_answer_ff <= out_answer_in;
         out_taps_ff   <= out_taps_in;
      end
   end

endmodule

`default_nettype wire
